@@ rtl/core/latency_histogram_stats_core_macros.svh @@
// Assertion macros shared by the latency histogram checker.
// Depends on nothing; included by the checker file only.
`ifndef LATENCY_HISTOGRAM_STATS_CORE_MACROS_SVH
`define LATENCY_HISTOGRAM_STATS_CORE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define LHS_ASSERT_IMP(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// Next-cycle implication checked outside reset.
`define LHS_ASSERT_NXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`endif

@@ rtl/core/lhs_pkg.sv @@
// Package for the latency histogram: widths, defaults and shared types.
// Depends on nothing.
package lhs_pkg;
   localparam int unsigned BucketsDefault = 32;
   localparam logic [15:0] WidthReset     = 16'd25;
   localparam logic [20:0] BoundMax       = 21'h1FFFFF;

   typedef enum logic [0:0] {
      OP_RECORD = 1'b0,
      OP_REPORT = 1'b1
   } op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture request, launch square
      logic rec_upd;    // apply record updates to totals
      logic bkt_step;   // compare one bucket bound / update count
      logic rpt_start;  // initialise report
      logic rpt_step;   // one bucket and one divide step
      logic finish;     // load output register
   } cmd_type;

   typedef struct packed {
      logic op;
      logic bkt_last;
      logic bkt_found;
      logic div_last;
   } sts_type;
endpackage

@@ rtl/core/latency_histogram_stats_core.sv @@
// Top level of the latency histogram with running statistics.
// Depends on lhs_pkg, lhs_ctrl and lhs_datapath.
//
// Usage: each request on req_ carries req_op (record or report) and a
// signed sample in eighths. Every request yields exactly one response on
// rsp_, in request order, with both channels using valid and ready.
// A record's response is ready once the scan finds the sample's bucket or
// reaches the last bucket; the scan walks the running bound one bucket a
// cycle. A report is done when the restoring divider, which forms the mean
// one quotient bit a cycle, has finished and the cumulative bucket walk
// that runs alongside it has reached the last bucket. One request is in
// progress at a time; the next is accepted as soon as the previous
// response has been loaded into the output register.
// The response sits in an output register, so the next request is taken
// and worked on while it waits. If that one finishes before the receiver
// takes the first response, it waits in the controller and the input stalls.
// Reset clears the totals and every bucket count, resets the minimum and
// maximum and sets bucket_width to 25. csr_write_enable writes bucket_width
// at once and should be used only while the block is idle.
module latency_histogram_stats_core #(
   parameter int unsigned BUCKETS = lhs_pkg::BucketsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [15:0]        csr_write_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic signed [31:0] req_sample_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [5:0]         rsp_bucket_hit,
   output logic [31:0]        rsp_total_samples,
   output logic signed [63:0] rsp_running_sum,
   output logic [63:0]        rsp_running_squares,
   output logic signed [31:0] rsp_lowest_seen,
   output logic signed [31:0] rsp_highest_seen,
   output logic signed [31:0] rsp_mean,
   output logic [20:0]        rsp_pct95_bound,
   output logic [20:0]        rsp_pct99_bound,
   output logic               rsp_empty_res
);
   import lhs_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // The controller sequences each request; the datapath holds the statistics.
   lhs_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .sts, .cmd
   );

   lhs_datapath #(.BUCKETS(BUCKETS)) u_dp (
      .clock, .reset, .csr_write_enable, .csr_write_data,
      .req_op, .req_sample_value, .cmd, .sts,
      .rsp_bucket_hit, .rsp_total_samples, .rsp_running_sum,
      .rsp_running_squares, .rsp_lowest_seen, .rsp_highest_seen,
      .rsp_mean, .rsp_pct95_bound, .rsp_pct99_bound, .rsp_empty_res
   );
endmodule

@@ rtl/core/lhs_ctrl.sv @@
// Controller state machine for the latency histogram.
// Depends on lhs_pkg.
module lhs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  lhs_pkg::sts_type sts,
   output lhs_pkg::cmd_type cmd
);
   import lhs_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SQ     = 6'b000010,
      ST_BKT    = 6'b000100,
      ST_RPT    = 6'b001000,
      ST_DONE   = 6'b010000,
      ST_HOLD   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;

   // Output register may be full while a new request is accepted.
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff && !rsp_ready;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            if (sts.op == OP_RECORD) begin
               cmd.rec_upd = 1'b1;
               state_in    = ST_BKT;
            end else begin
               cmd.rpt_start = 1'b1;
               state_in      = ST_RPT;
            end
         end
         ST_BKT: begin
            cmd.bkt_step = 1'b1;
            if (sts.bkt_found || sts.bkt_last) state_in = ST_DONE;
         end
         ST_RPT: begin
            cmd.rpt_step = 1'b1;
            if (sts.div_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               valid_in   = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_HOLD: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end
endmodule

@@ rtl/core/lhs_datapath.sv @@
// Datapath for the latency histogram: totals, bucket counts, divider, output register.
// Depends on lhs_pkg.
module lhs_datapath #(
   parameter int unsigned BUCKETS = lhs_pkg::BucketsDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [15:0]         csr_write_data,
   input  logic                req_op,
   input  logic signed [31:0]  req_sample_value,
   input  lhs_pkg::cmd_type    cmd,
   output lhs_pkg::sts_type    sts,
   output logic [5:0]          rsp_bucket_hit,
   output logic [31:0]         rsp_total_samples,
   output logic signed [63:0]  rsp_running_sum,
   output logic [63:0]         rsp_running_squares,
   output logic signed [31:0]  rsp_lowest_seen,
   output logic signed [31:0]  rsp_highest_seen,
   output logic signed [31:0]  rsp_mean,
   output logic [20:0]         rsp_pct95_bound,
   output logic [20:0]         rsp_pct99_bound,
   output logic                rsp_empty_res
);
   import lhs_pkg::*;

   localparam int unsigned IW = $clog2(BUCKETS);
   localparam int unsigned CW = IW + 1;
   // Cumulative count of all buckets, and its product with 100.
   localparam int unsigned SW = 32 + CW;
   localparam int unsigned MW = SW + 7;
   localparam logic [IW-1:0] LastIdx = IW'(BUCKETS - 1);
   localparam logic [5:0] NoHit = 6'(BUCKETS);

   logic [15:0]        width_ff;
   logic               op_ff;
   logic signed [31:0] smp_ff;
   logic [63:0]        sq_ff;
   logic [31:0]        tot_ff;
   logic signed [63:0] sum_ff;
   logic [63:0]        sqs_ff;
   logic signed [31:0] min_ff, max_ff;
   logic [31:0]        cnt_ff [BUCKETS];
   logic [IW-1:0]      idx_ff;
   logic [31:0]        bound_ff;   // running bound, 16+IW bits plus headroom
   logic [SW-1:0]      cum_ff;
   logic               walk_done_ff;
   logic               got95_ff, got99_ff;
   logic [20:0]        p95_ff, p99_ff;
   logic [6:0]         dstep_ff;
   logic [63:0]        quo_ff;     // magnitude quotient being built
   logic [32:0]        rem_ff;
   logic [63:0]        dvd_ff;     // magnitude dividend shifting out
   logic               neg_ff;
   logic [5:0]         hit_ff;
   logic               hit_done_ff;

   // Square of the magnitude, registered at load.
   logic [31:0] mag;
   assign mag = req_sample_value[31] ? 32'(-req_sample_value) : req_sample_value;

   // Saturating adds.
   logic signed [64:0] sum_wide;
   logic [64:0]        sqs_wide;
   assign sum_wide = {sum_ff[63], sum_ff} + {{33{smp_ff[31]}}, smp_ff};
   assign sqs_wide = {1'b0, sqs_ff} + {1'b0, sq_ff};

   // Bucket compare and cumulative thresholds.
   logic          le_bound;
   logic [SW-1:0] cum_next;
   logic [MW-1:0] lhs_cmp, t95, t99;
   logic [20:0]   bnd_clamp;
   assign le_bound  = smp_ff[31] || ({1'b0, smp_ff[30:0]} <= bound_ff);
   assign cum_next  = cum_ff + SW'(cnt_ff[idx_ff]);
   assign lhs_cmp   = MW'(cum_next) * MW'(100);
   assign t95       = MW'(tot_ff) * MW'(95);
   assign t99       = MW'(tot_ff) * MW'(99);
   assign bnd_clamp = (bound_ff > 32'(BoundMax)) ? BoundMax : bound_ff[20:0];

   // Restoring division: one dividend bit per step.
   logic [32:0] rem_sh, rem_sub;
   logic        q_bit;
   assign rem_sh  = {rem_ff[31:0], dvd_ff[63]};
   assign rem_sub = rem_sh - {1'b0, tot_ff};
   assign q_bit   = !rem_sub[32];

   assign sts.op        = op_ff;
   assign sts.bkt_last  = (idx_ff == LastIdx);
   assign sts.bkt_found = hit_done_ff;
   assign sts.div_last  = (dstep_ff == 7'd64) && walk_done_ff;

   always_ff @(posedge clock) begin
      if (reset) width_ff <= WidthReset;
      else if (csr_write_enable) width_ff <= csr_write_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tot_ff <= '0;
         sum_ff <= '0;
         sqs_ff <= '0;
         min_ff <= 32'sh7FFFFFFF;
         max_ff <= 32'sh80000000;
         for (int i = 0; i < BUCKETS; i++) cnt_ff[i] <= '0;
      end else begin
         if (cmd.rec_upd) begin
            if (tot_ff != '1) tot_ff <= tot_ff + 32'd1;
            if (sum_wide[64] != sum_wide[63])
               sum_ff <= sum_wide[64] ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF;
            else sum_ff <= sum_wide[63:0];
            sqs_ff <= sqs_wide[64] ? '1 : sqs_wide[63:0];
            if (smp_ff < min_ff) min_ff <= smp_ff;
            if (smp_ff > max_ff) max_ff <= smp_ff;
         end
         if (cmd.bkt_step && !hit_done_ff && le_bound && cnt_ff[idx_ff] != '1)
            cnt_ff[idx_ff] <= cnt_ff[idx_ff] + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_op;
         smp_ff <= req_sample_value;
         sq_ff  <= 64'(mag) * 64'(mag);
      end
      if (cmd.rec_upd || cmd.rpt_start) begin
         idx_ff       <= '0;
         bound_ff     <= 32'(width_ff);
         hit_ff       <= NoHit;
         hit_done_ff  <= 1'b0;
         cum_ff       <= '0;
         walk_done_ff <= 1'b0;
         got95_ff     <= 1'b0;
         got99_ff     <= 1'b0;
         p95_ff       <= '0;
         p99_ff       <= '0;
         dstep_ff     <= '0;
         quo_ff       <= '0;
         rem_ff       <= '0;
         neg_ff       <= sum_ff[63];
         dvd_ff       <= sum_ff[63] ? 64'(-sum_ff) : sum_ff;
      end
      if (cmd.bkt_step && !hit_done_ff) begin
         if (le_bound) begin
            hit_ff      <= 6'(idx_ff);
            hit_done_ff <= 1'b1;
         end else if (idx_ff != LastIdx) begin
            idx_ff   <= idx_ff + IW'(1);
            bound_ff <= bound_ff + 32'(width_ff);
         end
      end
      if (cmd.rpt_step) begin
         if (dstep_ff != 7'd64) begin
            dstep_ff <= dstep_ff + 7'd1;
            dvd_ff   <= {dvd_ff[62:0], 1'b0};
            quo_ff   <= {quo_ff[62:0], q_bit};
            rem_ff   <= q_bit ? rem_sub : rem_sh;
         end
         // The bucket walk adds one bucket a cycle until the last is in.
         if (!walk_done_ff) begin
            cum_ff <= cum_next;
            if (!got95_ff && lhs_cmp >= t95) begin
               got95_ff <= 1'b1;
               p95_ff   <= bnd_clamp;
            end
            if (!got99_ff && lhs_cmp >= t99) begin
               got99_ff <= 1'b1;
               p99_ff   <= bnd_clamp;
            end
            if (idx_ff != LastIdx) begin
               idx_ff   <= idx_ff + IW'(1);
               bound_ff <= bound_ff + 32'(width_ff);
            end else walk_done_ff <= 1'b1;
         end
      end
   end

   // Clamp the signed quotient to 32 bits.
   logic signed [31:0] mean_val;
   always_comb begin
      if (neg_ff) mean_val = (quo_ff > 64'h80000000) ? 32'sh80000000 : 32'(-quo_ff);
      else        mean_val = (quo_ff > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : quo_ff[31:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_total_samples   <= tot_ff;
         rsp_running_sum     <= sum_ff;
         rsp_running_squares <= sqs_ff;
         rsp_lowest_seen     <= (tot_ff != '0) ? min_ff : '0;
         rsp_highest_seen    <= (tot_ff != '0) ? max_ff : '0;
         if (op_ff == OP_RECORD) begin
            rsp_bucket_hit  <= hit_ff;
            rsp_mean        <= '0;
            rsp_pct95_bound <= '0;
            rsp_pct99_bound <= '0;
            rsp_empty_res   <= 1'b0;
         end else begin
            rsp_bucket_hit  <= NoHit;
            rsp_empty_res   <= (tot_ff == '0);
            rsp_mean        <= (tot_ff == '0) ? '0 : mean_val;
            rsp_pct95_bound <= (tot_ff == '0) ? '0 : p95_ff;
            rsp_pct99_bound <= (tot_ff == '0) ? '0 : p99_ff;
         end
      end
   end
endmodule

@@ rtl/core/lhs_checker.sv @@
// Port-level checker for the latency histogram, bound to the top level.
// Depends on latency_histogram_stats_core_macros.svh.
`include "latency_histogram_stats_core_macros.svh"
module lhs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [5:0]  rsp_bucket_hit,
   input logic        rsp_empty_res,
   input logic [31:0] rsp_mean
);
   `LHS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped")
   `LHS_ASSERT_NXT(a_no_back, clock, reset, req_valid && req_ready, !req_ready, "accepted twice")
   `LHS_ASSERT_IMP(a_empty_mean, clock, reset, rsp_valid && rsp_empty_res, rsp_mean == 32'd0, "mean on empty")
   `LHS_ASSERT_NXT(a_hit_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_bucket_hit), "response moved")
endmodule

bind latency_histogram_stats_core lhs_checker u_lhs_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_bucket_hit, .rsp_empty_res, .rsp_mean
);

@@ tb/tb.sv @@
// Self-checking testbench for latency_histogram_stats_core: a sample and report
// predictor, random stimulus over several bucket widths and idling patterns.
// Depends on lhs_pkg and the latency_histogram_stats_core RTL.
`timescale 1ns / 100ps

module tb;
   import lhs_pkg::*;

   localparam int unsigned NumBuckets = 32;
   localparam longint unsigned BoundClamp = 64'd2097151;
   localparam int unsigned DrainCycles = 100;

   // One expected response, field for field as it leaves the block.
   typedef struct {
      logic [5:0]         bucket_hit;
      logic [31:0]        total_samples;
      logic signed [63:0] running_sum;
      logic [63:0]        running_squares;
      logic signed [31:0] lowest_seen;
      logic signed [31:0] highest_seen;
      logic signed [31:0] mean;
      logic [20:0]        pct95_bound;
      logic [20:0]        pct99_bound;
      logic               empty_res;
   } stats_rsp_t;

   logic               clock;
   logic               reset;
   logic               csr_write_enable;
   logic [15:0]        csr_write_data;
   logic               req_valid;
   logic               req_ready;
   op_type             req_op;
   logic signed [31:0] req_sample_value;
   logic               rsp_valid;
   logic               rsp_ready;
   stats_rsp_t         got;

   // Mirror of the histogram state kept by the predictor.
   logic [15:0]        width_mirror;
   logic [31:0]        count_mirror;
   longint             sum_mirror;
   longint unsigned    squares_mirror;
   logic signed [31:0] min_mirror;
   logic signed [31:0] max_mirror;
   logic [31:0]        bucket_mirror [NumBuckets];

   stats_rsp_t pending_stats [$];
   int         error_count;
   int         records_sent;
   int         reports_sent;
   int         responses_checked;
   int         send_idle_pct;
   int         recv_stall_pct;
   int         hold_len;
   int         hold_count;

   latency_histogram_stats_core dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_sample_value    (req_sample_value),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_bucket_hit      (got.bucket_hit),
      .rsp_total_samples   (got.total_samples),
      .rsp_running_sum     (got.running_sum),
      .rsp_running_squares (got.running_squares),
      .rsp_lowest_seen     (got.lowest_seen),
      .rsp_highest_seen    (got.highest_seen),
      .rsp_mean            (got.mean),
      .rsp_pct95_bound     (got.pct95_bound),
      .rsp_pct99_bound     (got.pct99_bound),
      .rsp_empty_res       (got.empty_res)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Safety net: far beyond the slowest legal run.
   initial begin
      #50_000_000;
      $display("Timeout with %0d responses still outstanding", pending_stats.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Upper bound of bucket i at the current width, before clamping.
   function automatic longint bucket_bound(int unsigned i);
      return longint'(width_mirror) * longint'(i + 1);
   endfunction

   function automatic logic [20:0] clamped_bound(int unsigned i);
      longint unsigned b;
      b = longint'(bucket_bound(i));
      return (b > BoundClamp) ? BoundClamp[20:0] : b[20:0];
   endfunction

   // Applies one request to the mirrored state and forms its response.
   function automatic stats_rsp_t histogram_update(op_type op, logic signed [31:0] sample);
      stats_rsp_t      r;
      longint          s;
      longint unsigned sq;
      longint unsigned cum;
      longint unsigned tot;
      longint          quot;
      bit              got95;
      bit              got99;
      s = sample;
      r = '{default: '0};
      r.bucket_hit = 6'(NumBuckets);
      if (op == OP_RECORD) begin
         sq = (s < 0) ? longint'(-s) : longint'(s);
         sq = sq * sq;
         if (count_mirror != 32'hFFFF_FFFF) count_mirror++;
         // The sum cannot reach its limits with 32-bit samples in this run,
         // but it saturates both ways all the same.
         if (s > 0 && sum_mirror > 64'sh7FFF_FFFF_FFFF_FFFF - s)
            sum_mirror = 64'sh7FFF_FFFF_FFFF_FFFF;
         else if (s < 0 && sum_mirror < -64'sh7FFF_FFFF_FFFF_FFFF - 1 - s)
            sum_mirror = -64'sh7FFF_FFFF_FFFF_FFFF - 1;
         else
            sum_mirror = sum_mirror + s;
         squares_mirror = (squares_mirror > ~64'd0 - sq) ? ~64'd0 : squares_mirror + sq;
         if (sample < min_mirror) min_mirror = sample;
         if (sample > max_mirror) max_mirror = sample;
         for (int unsigned i = 0; i < NumBuckets; i++) begin
            if (s <= bucket_bound(i)) begin
               if (bucket_mirror[i] != 32'hFFFF_FFFF) bucket_mirror[i]++;
               r.bucket_hit = 6'(i);
               break;
            end
         end
      end else if (count_mirror == 0) begin
         r.empty_res = 1'b1;
      end else begin
         tot = count_mirror;
         quot = sum_mirror / longint'(tot);
         if (quot > 64'sd2147483647) quot = 64'sd2147483647;
         if (quot < -64'sd2147483648) quot = -64'sd2147483648;
         r.mean = quot[31:0];
         cum = 0;
         got95 = 0;
         got99 = 0;
         // Each percentile is taken at the first bucket that reaches it.
         for (int unsigned i = 0; i < NumBuckets; i++) begin
            cum += bucket_mirror[i];
            if (!got95 && cum * 100 >= tot * 95) begin
               r.pct95_bound = clamped_bound(i);
               got95 = 1;
            end
            if (!got99 && cum * 100 >= tot * 99) begin
               r.pct99_bound = clamped_bound(i);
               got99 = 1;
            end
         end
      end
      r.total_samples = count_mirror;
      r.running_sum = sum_mirror;
      r.running_squares = squares_mirror;
      r.lowest_seen = (count_mirror != 0) ? min_mirror : 32'sd0;
      r.highest_seen = (count_mirror != 0) ? max_mirror : 32'sd0;
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] seen, logic [63:0] wanted);
      $display("%0t: response %0d field %s got %h expected %h",
               $realtime, responses_checked, field, seen, wanted);
      error_count++;
   endtask

   // Sends one request. Called at a rising edge; returns at the edge where
   // the request is taken, leaving valid high so back-to-back requests
   // never see valid dropped and raised in the same step.
   task automatic send_request(op_type op, logic signed [31:0] sample);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_sample_value <= sample;
      do @(posedge clock); while (!req_ready);
      pending_stats.push_back(histogram_update(op, sample));
      if (op == OP_RECORD) records_sent++;
      else reports_sent++;
   endtask

   // Waits until every response is back, so that no request is left in the
   // block, and idles on before anything touches the register.
   task automatic drain;
      req_valid <= 1'b0;
      while (pending_stats.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic set_bucket_width(logic [15:0] w);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data <= w;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      width_mirror = w;
   endtask

   // Samples mostly fall inside or just beyond the bucket range, with
   // negatives and full-range values mixed in.
   function automatic logic signed [31:0] pick_sample();
      int unsigned mode;
      int unsigned span;
      mode = $urandom_range(99);
      span = int'(width_mirror) * 36 + 8;
      if (mode < 60) return $urandom_range(span, 0);
      if (mode < 75) return -$signed($urandom_range(span, 0));
      if (mode < 80) return ($urandom_range(1)) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      return $urandom;
   endfunction

   task automatic test_directed;
      send_request(OP_REPORT, 32'sd0);
      send_request(OP_RECORD, 32'sd0);
      send_request(OP_RECORD, 32'sd25);
      send_request(OP_RECORD, 32'sd26);
      send_request(OP_RECORD, -32'sd1);
      send_request(OP_RECORD, 32'sd800);
      send_request(OP_RECORD, 32'sd801);
      send_request(OP_REPORT, 32'sh7FFF_FFFF);
      send_request(OP_RECORD, 32'sh7FFF_FFFF);
      // Repeated most-negative samples drive the sum of squares into saturation.
      repeat (5) send_request(OP_RECORD, 32'sh8000_0000);
      send_request(OP_REPORT, -32'sd1);
      send_request(OP_RECORD, 32'sd1);
      send_request(OP_REPORT, 32'sd0);
   endtask

   // A zero width puts every bound at zero; the widest width gives the
   // largest bounds the register allows.
   task automatic test_width_extremes;
      set_bucket_width(16'd0);
      send_request(OP_RECORD, -32'sd5);
      send_request(OP_RECORD, 32'sd0);
      send_request(OP_RECORD, 32'sd3);
      send_request(OP_REPORT, 32'sd0);
      set_bucket_width(16'hFFFF);
      send_request(OP_RECORD, 32'sd2097120);
      send_request(OP_RECORD, 32'sd2097121);
      send_request(OP_RECORD, 32'sd65535);
      send_request(OP_REPORT, 32'sd0);
      set_bucket_width(16'd1);
      send_request(OP_RECORD, 32'sd32);
      send_request(OP_RECORD, 32'sd33);
      send_request(OP_REPORT, 32'sd0);
   endtask

   task automatic test_random(int n, int idle, int stall, logic [15:0] w);
      set_bucket_width(w);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      repeat (n) begin
         if ($urandom_range(7) == 0) send_request(OP_REPORT, $urandom);
         else send_request(OP_RECORD, pick_sample());
      end
   endtask

   // Holds the receiver off for a long stretch while requests keep coming,
   // so the block fills and pushes back on its input.
   task automatic test_backpressure;
      drain();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_len = 600;
      repeat (40) begin
         if ($urandom_range(3) == 0) send_request(OP_REPORT, 32'sd0);
         else send_request(OP_RECORD, pick_sample());
      end
   endtask

   // Receiver: random stalls, or a counted hold-off when one is asked for.
   always @(posedge clock) begin
      if (hold_len != 0) begin
         hold_count = hold_len;
         hold_len = 0;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_count != 0) begin
         hold_count--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Response checker: compares each accepted response with the oldest
   // outstanding prediction.
   always @(posedge clock) begin
      stats_rsp_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_stats.size() == 0) begin
            $display("%0t: response with nothing outstanding", $realtime);
            error_count++;
         end else begin
            want = pending_stats.pop_front();
            if (got.bucket_hit !== want.bucket_hit)
               report_mismatch("bucket_hit", 64'(got.bucket_hit), 64'(want.bucket_hit));
            if (got.total_samples !== want.total_samples)
               report_mismatch("total_samples", 64'(got.total_samples),
                               64'(want.total_samples));
            if (got.running_sum !== want.running_sum)
               report_mismatch("running_sum", got.running_sum, want.running_sum);
            if (got.running_squares !== want.running_squares)
               report_mismatch("running_squares", got.running_squares,
                               want.running_squares);
            if (got.lowest_seen !== want.lowest_seen)
               report_mismatch("lowest_seen", 64'(got.lowest_seen), 64'(want.lowest_seen));
            if (got.highest_seen !== want.highest_seen)
               report_mismatch("highest_seen", 64'(got.highest_seen),
                               64'(want.highest_seen));
            if (got.mean !== want.mean)
               report_mismatch("mean", 64'(got.mean), 64'(want.mean));
            if (got.pct95_bound !== want.pct95_bound)
               report_mismatch("pct95_bound", 64'(got.pct95_bound), 64'(want.pct95_bound));
            if (got.pct99_bound !== want.pct99_bound)
               report_mismatch("pct99_bound", 64'(got.pct99_bound), 64'(want.pct99_bound));
            if (got.empty_res !== want.empty_res)
               report_mismatch("empty_res", 64'(got.empty_res), 64'(want.empty_res));
         end
         responses_checked++;
      end
   end

   initial begin
      error_count = 0;
      records_sent = 0;
      reports_sent = 0;
      responses_checked = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_len = 0;
      hold_count = 0;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_op = OP_RECORD;
      req_sample_value = '0;
      width_mirror = WidthReset;
      count_mirror = 0;
      sum_mirror = 0;
      squares_mirror = 0;
      min_mirror = 32'sh7FFF_FFFF;
      max_mirror = 32'sh8000_0000;
      foreach (bucket_mirror[i]) bucket_mirror[i] = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_width_extremes();
      test_random(450, 0, 0, 16'd25);
      test_random(450, 88, 0, 16'($urandom_range(200, 2)));
      test_random(450, 0, 88, 16'($urandom_range(65535, 1)));
      test_backpressure();
      test_random(450, 28, 28, 16'd4);
      drain();

      $display("Covered %0d records and %0d reports, %0d responses checked,",
               records_sent, reports_sent, responses_checked);
      $display("over bucket widths from zero to the widest, with idling and a long hold-off.");
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches", error_count);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
